### hdl/cfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the complex decimating FIR core.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int NUM_TAPS_DEF   = 96;
  localparam int DECIMATION_DEF = 8;

  localparam int SAMPLE_W   = 16;
  localparam int TAP_IDX_W  = 7;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int FRAC_BITS  = 15;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 32;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TAP    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } state_t;

  // one tap of the delay line together with its coefficient
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] coef;
    logic signed [SAMPLE_W-1:0] hist_i;
    logic signed [SAMPLE_W-1:0] hist_q;
  } cell_t;

  typedef struct packed {
    logic clear;
    logic prod_en;
    logic acc_en;
  } mac_ctrl_t;

endpackage

### hdl/cfr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_cell
// One tap cell: holds a coefficient and an I/Q history sample. Shifts the
// history on a new sample, rotates the whole entry around the ring during a
// dot product, and takes a coefficient write.
// ----------------------------------------------------------------------------
module cfr_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift,
  input  logic                                rotate,
  input  logic                                we,
  input  logic signed [cfr_pkg::SAMPLE_W-1:0] tap_value,
  input  cfr_pkg::cell_t                      din,
  output cfr_pkg::cell_t                      dout
);
  import cfr_pkg::*;

  cell_t entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else if (rotate) begin
      entry <= din;
    end else begin
      if (shift) begin
        entry.hist_i <= din.hist_i;
        entry.hist_q <= din.hist_q;
      end
      if (we) begin
        entry.coef <= tap_value;
      end
    end
  end

  assign dout = entry;

endmodule

### hdl/cfr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfr_mac
// Shared I/Q multiply-accumulate at the end of the cell ring, with
// round-half-even scaling by 2^-15 and 16-bit wrap.
// ----------------------------------------------------------------------------
module cfr_mac #(
  parameter int NUM_TAPS = cfr_pkg::NUM_TAPS_DEF
) (
  input  logic                                clk,
  input  cfr_pkg::mac_ctrl_t                  ctrl,
  input  cfr_pkg::cell_t                      tap,
  output logic signed [cfr_pkg::SAMPLE_W-1:0] res_i,
  output logic signed [cfr_pkg::SAMPLE_W-1:0] res_q
);
  import cfr_pkg::*;

  localparam int ACC_W = PROD_W + $clog2(NUM_TAPS) + 1;

  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_i;
  logic signed [ACC_W-1:0]  acc_q;

  always_ff @(posedge clk) begin
    if (ctrl.prod_en) begin
      prod_i <= tap.coef * tap.hist_i;
      prod_q <= tap.coef * tap.hist_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_i <= '0;
      acc_q <= '0;
    end else if (ctrl.acc_en) begin
      acc_i <= acc_i + ACC_W'(prod_i);
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  function automatic logic [SAMPLE_W-1:0] round_wrap(input logic signed [ACC_W-1:0] acc);
    logic [SAMPLE_W-1:0]  q;
    logic [FRAC_BITS-1:0] rem;
    logic [FRAC_BITS-1:0] half;
    logic                 up;
    q    = acc[FRAC_BITS +: SAMPLE_W];
    rem  = acc[FRAC_BITS-1:0];
    half = FRAC_BITS'(1) << (FRAC_BITS - 1);
    up   = (rem > half) || ((rem == half) && q[0]);
    return q + SAMPLE_W'(up);
  endfunction

  assign res_i = round_wrap(acc_i);
  assign res_q = round_wrap(acc_q);

endmodule

### hdl/complex_decimating_fir_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_decimating_fir_core
// Decimating FIR on complex 16-bit samples with shared real Q1.15 taps.
//
//   channel  | dir | tdata                                   | tuser
//   s_axis   | in  | sample_i, sample_q, tap_index, tap_value | command
//   m_axis   | out | out_i, out_q                            | -
//
// Tap writes and non-emitting samples are taken directly in IDLE. An emitting sample
// (every DECIMATION-th, starting with the first) walks RUN, FLUSH and DONE before IDLE:
// the cell ring rotates once past a single I/Q MAC pair, one tap per cycle.
// Reset clears history, taps and phase.
// A result waits in the output register while new transactions are taken;
// the next result is held back until that register is free.
// ----------------------------------------------------------------------------
module complex_decimating_fir_core #(
  parameter int NUM_TAPS   = cfr_pkg::NUM_TAPS_DEF,
  parameter int DECIMATION = cfr_pkg::DECIMATION_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample_i[15:0], sample_q[31:16], tap_index[38:32], tap_value[54:39]
  input  logic [cfr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command[0]
  input  logic [0:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // out_i[15:0], out_q[31:16]
  output logic [cfr_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import cfr_pkg::*;

  localparam int CNT_W = $clog2(NUM_TAPS);
  localparam int PH_W  = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  state_t state;
  state_t state_next;

  logic [CNT_W-1:0] cnt;
  logic [PH_W-1:0]  phase;

  logic signed [SAMPLE_W-1:0]  sample_i;
  logic signed [SAMPLE_W-1:0]  sample_q;
  logic        [TAP_IDX_W-1:0] tap_index;
  logic signed [SAMPLE_W-1:0]  tap_value;

  logic accept;
  logic is_sample;
  logic emit_start;
  logic last_tap;
  logic out_free;
  logic rotate;
  logic load_out;

  mac_ctrl_t ctrl;

  cell_t cell_q  [NUM_TAPS];
  cell_t cell_in [NUM_TAPS];

  logic signed [SAMPLE_W-1:0] res_i;
  logic signed [SAMPLE_W-1:0] res_q;
  logic signed [SAMPLE_W-1:0] out_i;
  logic signed [SAMPLE_W-1:0] out_q;
  logic                       out_valid;

  assign sample_i  = s_axis_tdata[15:0];
  assign sample_q  = s_axis_tdata[31:16];
  assign tap_index = s_axis_tdata[38:32];
  assign tap_value = s_axis_tdata[54:39];

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign is_sample  = (s_axis_tuser[0] == CMD_SAMPLE);
  assign emit_start = accept && is_sample && (phase == '0);
  assign last_tap   = (cnt == CNT_W'(NUM_TAPS - 1));
  assign out_free   = !out_valid || m_axis_tready;

  // cell ring
  assign cell_in[0] = rotate ? cell_q[NUM_TAPS-1]
                             : cell_t'{coef: cell_q[0].coef, hist_i: sample_i,
                                       hist_q: sample_q};

  for (genvar k = 1; k < NUM_TAPS; k++) begin : g_link
    assign cell_in[k] = cell_q[k-1];
  end

  for (genvar k = 0; k < NUM_TAPS; k++) begin : g_cell
    cfr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift     (accept && is_sample),
      .rotate    (rotate),
      .we        (accept && !is_sample && (tap_index == TAP_IDX_W'(k))),
      .tap_value (tap_value),
      .din       (cell_in[k]),
      .dout      (cell_q[k])
    );
  end

  cfr_mac #(
    .NUM_TAPS (NUM_TAPS)
  ) u_mac (
    .clk   (clk),
    .ctrl  (ctrl),
    .tap   (cell_q[NUM_TAPS-1]),
    .res_i (res_i),
    .res_q (res_q)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (accept && is_sample) begin
        phase <= (phase == PH_W'(DECIMATION - 1)) ? '0 : phase + PH_W'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (emit_start) state_next = ST_RUN;
      ST_RUN:   if (last_tap) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    rotate        = 1'b0;
    load_out      = 1'b0;
    ctrl          = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        ctrl.clear    = 1'b1;
      end
      ST_RUN: begin
        rotate       = 1'b1;
        ctrl.prod_en = 1'b1;
        ctrl.acc_en  = (cnt != '0);
      end
      ST_FLUSH: begin
        ctrl.acc_en = 1'b1;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_i <= res_i;
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_q, out_i};

`ifndef SYNTHESIS
  a_run_to_flush: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && last_tap |=> (state == ST_FLUSH))
    else $error("ring walk did not end after the last tap");

  a_emit_starts_run: assert property (@(posedge clk) disable iff (rst)
    emit_start |=> (state == ST_RUN) && (cnt == '0))
    else $error("emitting sample did not start the ring walk");

  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && is_sample) |=> $stable(phase))
    else $error("phase moved without a sample");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) && out_free |=> out_valid && (state == ST_IDLE))
    else $error("finished result not loaded");
`endif

endmodule

### tb/complex_decimating_fir_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_decimating_fir_core_test
// Self-checking bench for the complex decimating FIR core. A behavioral
// filter (tap store, I/Q delay lines, decimation phase) predicts every output
// transaction from the accepted input transactions. A checker compares each
// output against the oldest prediction, field by field. Directed extremes and
// rounding ties come first, then random traffic under several idle and stall
// mixes, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module complex_decimating_fir_core_test;

  import cfr_pkg::*;

  localparam int NUM_TAPS   = NUM_TAPS_DEF;
  localparam int DECIMATION = DECIMATION_DEF;
  localparam int DRAIN_WAIT = NUM_TAPS + 16;

  typedef struct packed {
    logic [SAMPLE_W-1:0] out_i;
    logic [SAMPLE_W-1:0] out_q;
  } iq_result_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // sample_i[15:0], sample_q[31:16], tap_index[38:32], tap_value[54:39]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // command[0]
  logic [0:0]            s_axis_tuser  = CMD_SAMPLE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_i[15:0], out_q[31:16]
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // filter state tracked by the bench
  logic signed [SAMPLE_W-1:0] taps   [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] hist_i [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] hist_q [NUM_TAPS];
  int unsigned                decim_phase;

  iq_result_t pending_outputs[$];
  iq_result_t want;
  int         error_count  = 0;
  int         tx_gap_pct   = 0;
  int         rx_stall_pct = 0;
  int         hold_req     = 0;
  int         hold_left    = 0;

  complex_decimating_fir_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic logic [SAMPLE_W-1:0] fir_sum_round(input logic use_q);
    longint acc;
    longint quo;
    longint rem;
    acc = 0;
    for (int k = 0; k < NUM_TAPS; k++) begin
      if (use_q)
        acc += longint'(taps[k]) * longint'(hist_q[k]);
      else
        acc += longint'(taps[k]) * longint'(hist_i[k]);
    end
    quo = acc >>> FRAC_BITS;
    rem = acc - (quo <<< FRAC_BITS);
    // round half to even
    if (rem > 16384 || (rem == 16384 && quo[0]))
      quo++;
    return quo[SAMPLE_W-1:0];
  endfunction

  task automatic advance_filter(input logic cmd, input logic [15:0] si, input logic [15:0] sq,
                                input logic [6:0] ti, input logic [15:0] tv);
    iq_result_t res;
    if (cmd == CMD_TAP) begin
      if (ti < NUM_TAPS)
        taps[ti] = tv;
    end else begin
      for (int k = NUM_TAPS - 1; k > 0; k--) begin
        hist_i[k] = hist_i[k-1];
        hist_q[k] = hist_q[k-1];
      end
      hist_i[0] = si;
      hist_q[0] = sq;
      if (decim_phase == 0) begin
        res.out_i = fir_sum_round(1'b0);
        res.out_q = fir_sum_round(1'b1);
        pending_outputs.push_back(res);
      end
      decim_phase = (decim_phase + 1 >= DECIMATION) ? 0 : decim_phase + 1;
    end
  endtask

  // called at a falling edge; returns at the next falling edge after acceptance
  task automatic send_item(input logic cmd, input logic [15:0] si, input logic [15:0] sq,
                           input logic [6:0] ti, input logic [15:0] tv);
    if ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, tv, ti, sq, si};
    s_axis_tuser  <= cmd;
    do @(posedge clk); while (!s_axis_tready);
    advance_filter(cmd, si, sq, ti, tv);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_word16();
    case ($urandom_range(3))
      0:       return ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
      1:       return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_tap_value();
    logic [15:0] v;
    case ($urandom_range(3))
      0: begin
        v = 16'd1 << $urandom_range(14);
        return ($urandom_range(1)) ? -v : v;
      end
      1:       return 16'($urandom_range(2047)) - 16'd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_item();
    logic [6:0] ti;
    ti = ($urandom_range(9) == 0) ? 7'($urandom_range(127, NUM_TAPS))
                                  : 7'($urandom_range(NUM_TAPS - 1));
    if ($urandom_range(99) < 20)
      send_item(CMD_TAP, 16'($urandom), 16'($urandom), ti, rand_tap_value());
    else
      send_item(CMD_SAMPLE, rand_word16(), rand_word16(), 7'($urandom), 16'($urandom));
  endtask

  task automatic wait_for_drain();
    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // tap extremes, ignored tap indexes, wrap on overflow, rounding ties
  task automatic test_directed();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    send_item(CMD_TAP, 16'h7FFF, 16'h8000, 7'd0, 16'h8000);
    send_item(CMD_TAP, 16'h0000, 16'hFFFF, 7'd95, 16'h7FFF);
    send_item(CMD_TAP, 16'h1234, 16'h5678, 7'd96, 16'h1111);
    send_item(CMD_TAP, 16'hFFFF, 16'hFFFF, 7'd127, 16'h7FFF);
    // -1.0 * -32768 wraps to -32768
    send_item(CMD_SAMPLE, 16'h8000, 16'h7FFF, 7'h7F, 16'hFFFF);
    send_item(CMD_SAMPLE, 16'h7FFF, 16'h8000, 7'h00, 16'h0000);
    send_item(CMD_SAMPLE, 16'hFFFF, 16'h0000, 7'h55, 16'hAAAA);
    send_item(CMD_SAMPLE, 16'h0000, 16'hFFFF, 7'h2A, 16'h5555);
    repeat (4) send_item(CMD_SAMPLE, rand_word16(), rand_word16(), 7'($urandom), 16'($urandom));
    send_item(CMD_TAP, 16'hFFFF, 16'h8000, 7'd0, 16'h4000);
    // 0.5 taps: 1.5 rounds up to 2, -0.5 rounds to 0
    send_item(CMD_SAMPLE, 16'd3, 16'hFFFF, 7'd0, 16'h0000);
    repeat (7) send_item(CMD_SAMPLE, rand_word16(), rand_word16(), 7'($urandom), 16'($urandom));
    send_item(CMD_TAP, 16'h0000, 16'h0000, 7'd0, 16'hC000);
    // -0.5 taps: -0.5 rounds to 0, 1.5 rounds to 2
    send_item(CMD_SAMPLE, 16'd1, 16'hFFFD, 7'd0, 16'h0000);
  endtask

  task automatic test_random(input int count, input int gap_pct, input int stall_pct);
    tx_gap_pct   = gap_pct;
    rx_stall_pct = stall_pct;
    repeat (count) send_random_item();
  endtask

  // output held off long enough that the core backs up into its input
  task automatic test_output_holdoff();
    tx_gap_pct   = 0;
    rx_stall_pct = 0;
    hold_req     = 6 * (NUM_TAPS + 3);
    repeat (40) send_item(CMD_SAMPLE, rand_word16(), rand_word16(), 7'($urandom), 16'($urandom));
  endtask

  task automatic test_drain_pause();
    tx_gap_pct   = 30;
    rx_stall_pct = 30;
    repeat (20) send_random_item();
    stop_sending();
    wait_for_drain();
    repeat (20) send_random_item();
  endtask

  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: unexpected output transaction, actual out_i=%h out_q=%h",
                 $time, m_axis_tdata[15:0], m_axis_tdata[31:16]);
        error_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (m_axis_tdata[15:0] !== want.out_i) begin
          $display("%0t: out_i mismatch, expected %h actual %h",
                   $time, want.out_i, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[31:16] !== want.out_q) begin
          $display("%0t: out_q mismatch, expected %h actual %h",
                   $time, want.out_q, m_axis_tdata[31:16]);
          error_count++;
        end
      end
    end
  end

  initial begin
    for (int k = 0; k < NUM_TAPS; k++) begin
      taps[k]   = '0;
      hist_i[k] = '0;
      hist_q[k] = '0;
    end
    decim_phase = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(330, 0, 0);
    test_random(330, 60, 0);
    test_random(330, 0, 60);
    test_random(330, 23, 23);
    test_output_holdoff();
    test_drain_pause();
    stop_sending();

    while (pending_outputs.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (error_count == 0 && pending_outputs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
